// ===== sv/lcd_pkg.sv =====
`timescale 1ns / 1ps

package lcd_pkg;

    localparam int NUM_REGS      = 8;
    localparam int CODE_W        = 13;
    localparam int CFG_IDX_W     = $clog2(NUM_REGS);
    localparam int POS_W         = 4;
    localparam int GREEN_W       = 8;
    localparam int LINES_W       = 8;
    localparam int WORD_BITS_DEF = 13;
    localparam int NUM_CODES_DEF = 8;
    localparam int PREAMBLE_BITS = 6;

    localparam logic [GREEN_W-1:0] GREEN_THRESHOLD = 8'h10;

    typedef logic [NUM_REGS-1:0][CODE_W-1:0] code_array_t;

    localparam code_array_t CODE_RESET = {
        13'h0AE8, 13'h0BA8, 13'h1BE8, 13'h1BA8,
        13'h0AAA, 13'h1AE8, 13'h0FA8, 13'h0EE8
    };

    typedef struct packed {
        logic               screen_uniform;
        logic [GREEN_W-1:0] green_level;
    } sample_t;

    typedef struct packed {
        logic [LINES_W-1:0] arm_lines;
        logic               word_complete;
    } step_res_t;

endpackage

// ===== sv/lcd_in_if.sv =====
`timescale 1ns / 1ps

interface lcd_in_if;
    import lcd_pkg::*;

    logic               valid;
    logic               ready;
    logic               screen_uniform;
    logic [GREEN_W-1:0] green_level;

    modport source (output valid, output screen_uniform, output green_level, input ready);
    modport sink   (input valid, input screen_uniform, input green_level, output ready);
endinterface

// ===== sv/lcd_out_if.sv =====
`timescale 1ns / 1ps

interface lcd_out_if;
    import lcd_pkg::*;

    logic               valid;
    logic               ready;
    logic [LINES_W-1:0] arm_lines;
    logic               word_complete;

    modport source (output valid, output arm_lines, output word_complete, input ready);
    modport sink   (input valid, input arm_lines, input word_complete, output ready);
endinterface

// ===== sv/lcd_code_regs.sv =====
`timescale 1ns / 1ps

module lcd_code_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [lcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lcd_pkg::CODE_W-1:0]     cfg_data,
    output lcd_pkg::code_array_t           codes
);
    import lcd_pkg::*;

    code_array_t codes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg <= CODE_RESET;
        end
        else if (cfg_wr_en)
        begin
            codes_reg[cfg_index] <= cfg_data;
        end
    end

    assign codes = codes_reg;

endmodule

// ===== sv/lcd_step.sv =====
`timescale 1ns / 1ps

module lcd_step #(
    parameter int WORD_BITS = lcd_pkg::WORD_BITS_DEF,
    parameter int NUM_CODES = lcd_pkg::NUM_CODES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  lcd_pkg::sample_t      sample_in,
    input  lcd_pkg::code_array_t  codes,
    output lcd_pkg::step_res_t    res
);
    import lcd_pkg::*;

    localparam int CMP_W = (WORD_BITS > CODE_W) ? WORD_BITS : CODE_W;

    logic [WORD_BITS-1:0] word_reg, word_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [LINES_W-1:0]   line_reg, line_next;

    logic                 hit;
    logic [WORD_BITS-1:0] word_or;
    logic [POS_W:0]       pos_inc;
    logic                 complete;
    logic [LINES_W-1:0]   match;

    always_comb
    begin
        hit     = sample_in.green_level > GREEN_THRESHOLD;
        word_or = word_reg | (WORD_BITS'(hit) << pos_reg);
        pos_inc = {1'b0, pos_reg} + (POS_W+1)'(1);
        if (pos_inc == (POS_W+1)'(PREAMBLE_BITS) && word_or == '0)
        begin
            pos_inc = '0;
        end
        complete = sample_in.screen_uniform && (pos_inc >= (POS_W+1)'(WORD_BITS));

        match = '0;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            match[i] = CMP_W'(word_or) == CMP_W'(codes[i]);
        end

        line_next = line_reg;
        if (!sample_in.screen_uniform)
        begin
            word_next = '0;
            pos_next  = '0;
        end
        else if (complete)
        begin
            word_next = '0;
            pos_next  = '0;
            line_next = line_reg ^ match;
        end
        else
        begin
            word_next = word_or;
            pos_next  = pos_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg <= '0;
            pos_reg  <= '0;
            line_reg <= '0;
        end
        else if (advance)
        begin
            word_reg <= word_next;
            pos_reg  <= pos_next;
            line_reg <= line_next;
        end
    end

    assign res.arm_lines     = line_next;
    assign res.word_complete = complete;

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pos_reg} < (POS_W+1)'(WORD_BITS))
        else $error("bit position past word length");

    a_clear_after_word: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.word_complete |=> pos_reg == '0 && word_reg == '0)
        else $error("word not cleared after completion");

    a_invalid_keeps_lines: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !sample_in.screen_uniform |=> line_reg == $past(line_reg) &&
            pos_reg == '0 && word_reg == '0)
        else $error("invalid frame changed arm lines or kept word");

    a_lines_only_on_word: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && res.word_complete) |=> $stable(line_reg))
        else $error("arm lines toggled without a completed word");

endmodule

// ===== sv/light_code_command_decoder_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Beat payload                         Handshake
// sample    in   screen_uniform, green_level[7:0]     valid/ready
// result    out  arm_lines[7:0], word_complete        valid/ready
// cfg       in   cfg_index[2:0], cfg_data[12:0]       cfg_wr_en, no stall
//
// One beat per cycle unless result stalls; input register feeds result register.
// The word/position/arm-line update plus eight code compares sit between them.
// rst_n is asynchronous: word, position and arm lines clear, codes reload defaults.
// A stalled result holds its register; the input register still takes one more beat.

module light_code_command_decoder_core #(
    parameter int WORD_BITS = lcd_pkg::WORD_BITS_DEF,
    parameter int NUM_CODES = lcd_pkg::NUM_CODES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lcd_in_if.sink                        sample,
    lcd_out_if.source                     result,
    input  logic                          cfg_wr_en,
    input  logic [lcd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcd_pkg::CODE_W-1:0]    cfg_data
);
    import lcd_pkg::*;

    logic        s1_valid_reg;
    sample_t     s1_reg;
    logic        out_valid_reg;
    step_res_t   out_reg;

    logic        out_free;
    logic        advance;
    logic        in_fire;
    code_array_t codes;
    step_res_t   res;

    assign out_free     = !out_valid_reg || result.ready;
    assign advance      = s1_valid_reg && out_free;
    assign sample.ready = !s1_valid_reg || out_free;
    assign in_fire      = sample.valid && sample.ready;

    lcd_code_regs u_codes (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .codes     (codes)
    );

    lcd_step #(
        .WORD_BITS (WORD_BITS),
        .NUM_CODES (NUM_CODES)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .sample_in (s1_reg),
        .codes     (codes),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_reg.screen_uniform <= sample.screen_uniform;
            s1_reg.green_level    <= sample.green_level;
        end
        if (advance)
        begin
            out_reg <= res;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.arm_lines     = out_reg.arm_lines;
    assign result.word_complete = out_reg.word_complete;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |=> out_valid_reg && $stable(out_reg))
        else $error("pending result overwritten");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_reg))
        else $error("held input beat lost");

    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat did not reach result register");

endmodule
